// ===== sv/wgjl_pkg.sv =====
`default_nettype none

package wgjl_pkg;

    // grid geometry and label size
    localparam int MAX_DIM    = 256;
    localparam int LABEL_BITS = 8;
    localparam int CELL_BITS  = 16;
    localparam int DIM_BITS   = 9;
    localparam int COST_BITS  = 17;
    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_JUMP  = 1'b1;

    // direction codes
    localparam logic [2:0] DIR_N  = 3'd0;
    localparam logic [2:0] DIR_S  = 3'd1;
    localparam logic [2:0] DIR_E  = 3'd2;
    localparam logic [2:0] DIR_W  = 3'd3;
    localparam logic [2:0] DIR_NE = 3'd4;
    localparam logic [2:0] DIR_NW = 3'd5;
    localparam logic [2:0] DIR_SE = 3'd6;
    localparam logic [2:0] DIR_SW = 3'd7;

    // configuration register indexes
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [2:0]            direction;
        logic [CELL_BITS-1:0]  node_cell;
        logic [CELL_BITS-1:0]  goal_cell;
        logic [7:0]            label_value;
    } wgjl_in_t;

    typedef struct packed {
        logic                  found;
        logic [CELL_BITS-1:0]  jump_cell;
        logic [COST_BITS-1:0]  cost_half;
    } wgjl_out_t;

    // row step of a direction
    function automatic logic signed [1:0] dir_dr(input logic [2:0] dir);
        logic signed [1:0] d;
        case (dir) inside
            DIR_N, DIR_NE, DIR_NW: d = -2'sd1;
            DIR_S, DIR_SE, DIR_SW: d = 2'sd1;
            default:               d = 2'sd0;
        endcase
        return d;
    endfunction

    // column step of a direction
    function automatic logic signed [1:0] dir_dc(input logic [2:0] dir);
        logic signed [1:0] d;
        case (dir) inside
            DIR_E, DIR_NE, DIR_SE: d = 2'sd1;
            DIR_W, DIR_NW, DIR_SW: d = -2'sd1;
            default:               d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/weighted_grid_jump_locator.sv =====
`default_nettype none

// Jump point locator over a 256 x 256 grid of 8-bit terrain labels held in one
// RAM with one write port and one registered read port (one read and one write
// per cycle). After reset a clearing pass writes label 0 to all 65536 cells,
// during which no transaction is accepted (configuration writes are taken).
// Items run one at a time. A cell write goes straight to the finish state. A
// diagonal jump makes 4 cell reads, then, when all four labels are nonzero, an
// 11-step bit-serial square root for the cost. A straight jump reads 6 cells
// around the start; when it scans on, the path cell and both side cells of
// each scanned cell go through the single RAM read port.
// A finished result waits in an output register while the next item is taken.
module weighted_grid_jump_locator (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire wgjl_pkg::wgjl_in_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output wgjl_pkg::wgjl_out_t       m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [8:0]           cfg_wdata
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH, ST_EVAL, ST_SCAN,
        ST_GOAL, ST_SQUARE, ST_SQRT, ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [15:0]              clr_addr_reg;
    wgjl_pkg::wgjl_in_t       item_reg;
    logic [2:0]               idx_reg;
    logic [9:0]               k_reg;
    logic [1:0]               sub_reg;
    logic                     rd_live_reg;
    logic                     rd_ok_reg;
    logic [2:0]               rd_tag_reg;
    logic [9:0]               rd_k_reg;
    logic [7:0]               cell_reg [0:5];
    logic [8:0]               m_reg;
    logic [9:0]               s_reg;
    logic [20:0]              sq_reg;
    logic [10:0]              root_reg;
    logic [3:0]               bit_reg;
    logic                     res_found_reg;
    logic [15:0]              res_cell_reg;
    logic [16:0]              res_cost_reg;
    wgjl_pkg::wgjl_out_t      out_reg;
    logic                     out_valid_reg;
    logic [8:0]               width_reg;
    logic [8:0]               height_reg;

    // label store
    logic [7:0]               mem [0:65535];
    logic [7:0]               mem_q;
    logic                     mem_we;
    logic [15:0]              mem_waddr;
    logic [7:0]               mem_wdata;
    logic [15:0]              mem_raddr;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    logic accept;
    assign accept = s_valid && s_ready;

    // output register load
    logic out_load;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_ready);

    // item geometry
    logic signed [10:0] r0, c0, dr, dc, pr, pc;
    logic               is_diag;
    logic [2:0]         last_idx;
    assign r0      = {3'b000, item_reg.node_cell[15:8]};
    assign c0      = {3'b000, item_reg.node_cell[7:0]};
    assign dr      = 11'(wgjl_pkg::dir_dr(item_reg.direction));
    assign dc      = 11'(wgjl_pkg::dir_dc(item_reg.direction));
    assign pr      = (dc != 11'sd0) ? 11'sd1 : 11'sd0;
    assign pc      = (dr != 11'sd0) ? 11'sd1 : 11'sd0;
    assign is_diag = item_reg.direction[2];
    assign last_idx = is_diag ? 3'd3 : 3'd5;

    // read position for the current fetch or scan slot
    logic signed [10:0] kk, kr, kc, rr, cc;
    logic               rd_issue, rd_ok;
    always_comb begin
        kk = {1'b0, k_reg};
        kr = (dr == 11'sd0) ? 11'sd0 : ((dr < 11'sd0) ? -kk : kk);
        kc = (dc == 11'sd0) ? 11'sd0 : ((dc < 11'sd0) ? -kk : kk);
        rr = r0;
        cc = c0;
        rd_issue = 1'b0;
        if (state_reg == ST_SCAN) begin
            rd_issue = 1'b1;
            case (sub_reg)
                2'd1:    begin rr = r0 + kr - pr; cc = c0 + kc - pc; end
                2'd2:    begin rr = r0 + kr + pr; cc = c0 + kc + pc; end
                default: begin rr = r0 + kr;      cc = c0 + kc;      end
            endcase
        end else if (state_reg == ST_FETCH && idx_reg <= last_idx) begin
            rd_issue = 1'b1;
            if (is_diag) begin
                case (idx_reg)
                    3'd1:    begin rr = r0 + dr; cc = c0;      end
                    3'd2:    begin rr = r0;      cc = c0 + dc; end
                    3'd3:    begin rr = r0 + dr; cc = c0 + dc; end
                    default: begin rr = r0;      cc = c0;      end
                endcase
            end else begin
                case (idx_reg)
                    3'd1:    begin rr = r0 + dr;      cc = c0 + dc;      end
                    3'd2:    begin rr = r0 - pr;      cc = c0 - pc;      end
                    3'd3:    begin rr = r0 + pr;      cc = c0 + pc;      end
                    3'd4:    begin rr = r0 + dr - pr; cc = c0 + dc - pc; end
                    3'd5:    begin rr = r0 + dr + pr; cc = c0 + dc + pc; end
                    default: begin rr = r0;           cc = c0;           end
                endcase
            end
        end
        rd_ok = (rr >= 11'sd0) && (cc >= 11'sd0)
             && (rr < 11'sd256) && (cc < 11'sd256)
             && (rr[8:0] < height_reg) && (cc[8:0] < width_reg);
    end

    assign mem_raddr = {rr[7:0], cc[7:0]};
    assign mem_we    = (state_reg == ST_CLEAR) || (accept && s_data.cmd == wgjl_pkg::CMD_WRITE);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : s_data.node_cell;
    assign mem_wdata = (state_reg == ST_CLEAR) ? 8'd0 : s_data.label_value;

    // ram with separate write and read ports, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    logic [7:0] rd_data;
    assign rd_data = rd_ok_reg ? mem_q : 8'd0;

    // straight start decision
    logic [9:0] side_sum;
    logic       straight_stop;
    assign side_sum = 10'(cell_reg[2]) + 10'(cell_reg[3]) + 10'(cell_reg[4]) + 10'(cell_reg[5]);
    assign straight_stop = (cell_reg[0] != cell_reg[1]) || (side_sum[9:2] != cell_reg[0]);

    // expected label in a scan slot
    logic [7:0] scan_expect;
    always_comb begin
        case (rd_tag_reg[1:0])
            2'd1:    scan_expect = cell_reg[2];
            2'd2:    scan_expect = cell_reg[3];
            default: scan_expect = cell_reg[0];
        endcase
    end

    // goal on path
    logic signed [10:0] gdist, mm, gm_fin, mr, mc;
    logic               goal_hit;
    always_comb begin
        gdist = 11'sd0;
        if (dr == 11'sd0 && item_reg.goal_cell[15:8] == item_reg.node_cell[15:8]) begin
            gdist = {3'b000, item_reg.goal_cell[7:0]} - c0;
            if (dc < 11'sd0) gdist = -gdist;
        end else if (dc == 11'sd0 && item_reg.goal_cell[7:0] == item_reg.node_cell[7:0]) begin
            gdist = {3'b000, item_reg.goal_cell[15:8]} - r0;
            if (dr < 11'sd0) gdist = -gdist;
        end
        mm       = {2'b00, m_reg};
        goal_hit = (gdist >= 11'sd1) && (gdist <= mm);
        gm_fin   = goal_hit ? gdist : mm;
        mr = (dr == 11'sd0) ? r0 : ((dr < 11'sd0) ? r0 - gm_fin : r0 + gm_fin);
        mc = (dc == 11'sd0) ? c0 : ((dc < 11'sd0) ? c0 - gm_fin : c0 + gm_fin);
    end

    logic [17:0] scan_cost;
    assign scan_cost = {17'(cell_reg[0]) * 17'(gm_fin[8:0]), 1'b0};

    // square root step
    logic [10:0] root_cand, root_new;
    logic [21:0] cand_sq;
    assign root_cand = root_reg | (11'd1 << bit_reg);
    assign cand_sq   = root_cand * root_cand;
    assign root_new  = (cand_sq <= {1'b0, sq_reg}) ? root_cand : root_reg;

    logic [7:0] next_row, next_col;
    assign next_row = 8'(r0 + dr);
    assign next_col = 8'(c0 + dc);

    // sequencer, config and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            rd_live_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
        end else begin
            rd_live_reg <= rd_issue;
            rd_ok_reg   <= rd_ok;
            rd_tag_reg  <= (state_reg == ST_SCAN) ? {1'b0, sub_reg} : idx_reg;
            rd_k_reg    <= k_reg;

            if (cfg_valid) begin
                if (cfg_index == wgjl_pkg::CFG_MAP_WIDTH) width_reg <= cfg_wdata;
                else height_reg <= cfg_wdata;
            end

            out_valid_reg <= out_load || (out_valid_reg && !m_ready);

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 16'd1;
                    if (clr_addr_reg == 16'hFFFF) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        item_reg <= s_data;
                        idx_reg  <= 3'd0;
                        if (s_data.cmd == wgjl_pkg::CMD_WRITE) begin
                            res_found_reg <= 1'b1;
                            res_cell_reg  <= s_data.node_cell;
                            res_cost_reg  <= '0;
                            state_reg     <= ST_FINISH;
                        end else begin
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                ST_FETCH: begin
                    if (rd_issue) idx_reg <= idx_reg + 3'd1;
                    if (rd_live_reg) begin
                        cell_reg[rd_tag_reg] <= rd_data;
                        if (rd_tag_reg == last_idx) state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (is_diag && cell_reg[0] != 8'd0 && cell_reg[1] != 8'd0
                        && cell_reg[2] != 8'd0 && cell_reg[3] != 8'd0) begin
                        s_reg     <= 10'(cell_reg[0]) + 10'(cell_reg[1])
                                   + 10'(cell_reg[2]) + 10'(cell_reg[3]);
                        state_reg <= ST_SQUARE;
                    end else if (!is_diag && cell_reg[1] != 8'd0 && !straight_stop) begin
                        k_reg     <= 10'd2;
                        sub_reg   <= 2'd0;
                        state_reg <= ST_SCAN;
                    end else if (!is_diag && cell_reg[1] != 8'd0) begin
                        res_found_reg <= 1'b1;
                        res_cell_reg  <= {next_row, next_col};
                        res_cost_reg  <= 17'(cell_reg[0]) + 17'(cell_reg[1]);
                        state_reg     <= ST_FINISH;
                    end else begin
                        res_found_reg <= 1'b0;
                        res_cell_reg  <= '0;
                        res_cost_reg  <= '0;
                        state_reg     <= ST_FINISH;
                    end
                end
                ST_SCAN: begin
                    // issue runs one slot ahead of the compare
                    if (sub_reg == 2'd2) begin
                        sub_reg <= 2'd0;
                        k_reg   <= k_reg + 10'd1;
                    end else begin
                        sub_reg <= sub_reg + 2'd1;
                    end
                    if (rd_live_reg && rd_data != scan_expect) begin
                        m_reg     <= 9'(rd_k_reg - 10'd1);
                        state_reg <= ST_GOAL;
                    end
                end
                ST_GOAL: begin
                    res_found_reg <= 1'b1;
                    res_cell_reg  <= {mr[7:0], mc[7:0]};
                    res_cost_reg  <= (scan_cost > 18'(wgjl_pkg::COST_MAX))
                                   ? wgjl_pkg::COST_MAX : scan_cost[16:0];
                    state_reg     <= ST_FINISH;
                end
                ST_SQUARE: begin
                    sq_reg    <= {20'(s_reg) * 20'(s_reg), 1'b0};
                    root_reg  <= '0;
                    bit_reg   <= 4'd10;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    root_reg <= root_new;
                    bit_reg  <= bit_reg - 4'd1;
                    if (bit_reg == 4'd0) begin
                        res_found_reg <= 1'b1;
                        res_cell_reg  <= {next_row, next_col};
                        res_cost_reg  <= 17'({root_new[10:2], 1'b0});
                        state_reg     <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        out_reg.found     <= res_found_reg;
                        out_reg.jump_cell <= res_cell_reg;
                        out_reg.cost_half <= res_cost_reg;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ram written only by the clearing pass or an accepted cell write
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR)
                || (accept && s_data.cmd == wgjl_pkg::CMD_WRITE))
        else $error("unexpected ram write");

    // partial root never overshoots
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> (22'(root_reg * root_reg) <= {1'b0, sq_reg}))
        else $error("square root overshoot");

    // scan distance k stays at or below 258
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (k_reg <= 10'd258))
        else $error("scan ran past the grid");

    // a result appears only from the finish step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result without finish");

endmodule

`default_nettype wire
